// File: src/markov_page_prefetch_predictor_core_assert.svh
// Assertion macros shared by the predictor RTL.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef MARKOV_PAGE_PREFETCH_PREDICTOR_CORE_ASSERT_SVH
`define MARKOV_PAGE_PREFETCH_PREDICTOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MKV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mkv_pkg.sv
`timescale 1ns / 1ps

package mkv_pkg;

    // Fixed field widths of the transaction payloads
    localparam int PROC_BITS       = 5;
    localparam int PC_BITS         = 12;
    localparam int PAGE_FIELD_BITS = 5;
    localparam int MASK_BITS       = 20;

    typedef struct packed {
        logic [PROC_BITS-1:0] process_index;
        logic                 active;
        logic [PC_BITS-1:0]   pc;
    } t_in_item;

    typedef struct packed {
        logic [PAGE_FIELD_BITS-1:0] current_page;
        logic [MASK_BITS-1:0]       resident_mask;
    } t_out_item;

    // Controller to datapath commands, at most one per cycle
    typedef struct packed {
        logic clear;     // write reset contents at the sweep address
        logic accept;    // capture input transaction
        logic div;       // compute page, read last page
        logic check;     // record last page, read seen row of last page
        logic mark;      // set the new transition bit
        logic row_rd;    // read seen row of current page
        logic row_wr;    // copy it to the snapshot, start mask
        logic scan;      // read one snapshot row
        logic load_out;  // load result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic item_ok;
        logic need_mark;
        logic scan_last;
        logic out_busy;
    } t_stat;

endpackage

// File: src/markov_page_prefetch_predictor_core.sv
`timescale 1ns / 1ps
// Per-process Markov page predictor.
// Input channel i_valid/o_ready carries {process_index, active, pc}; output
// channel o_valid/i_ready carries {current_page, resident_mask}. A set mask
// bit means keep the page resident, a clear bit means page it out.
// Inactive transactions, process indexes >= PROCESSES and pages >= PAGES
// produce no result and leave the state untouched; they are dropped after
// the divide and check steps, and o_ready then returns.
// A valid transaction goes through divide, check, mark (only when a new
// transition is recorded), row read, row write, the snapshot scan and a
// drain step, then loads its result and raises o_ready again; no new
// transaction is accepted before that. The scan reads one snapshot row
// per cycle from a single RAM read port and ORs it in.
// The result sits in the output register from the end of the last step
// until taken. While the receiver stalls with a result pending, the next
// transaction is still accepted and worked up to its final step, where it
// waits for the output register to free.
// After reset the seen-transition and snapshot RAMs are initialized by a
// sweep over all PROCESSES * 2**clog2(PAGES) rows (640 at the defaults), with
// o_ready low throughout.
module markov_page_prefetch_predictor_core #(
    parameter int PROCESSES  = 20,
    parameter int PAGES      = 20,
    parameter int PAGE_BYTES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mkv_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output mkv_pkg::t_out_item o_item
);

    mkv_pkg::t_cmd  w_cmd;
    mkv_pkg::t_stat w_stat;

    mkv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    mkv_dp #(
        .PROCESSES  (PROCESSES),
        .PAGES      (PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (w_cmd),
        .i_out_ready (i_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_valid),
        .o_out_item  (o_item)
    );

    `include "markov_page_prefetch_predictor_core_assert.svh"

    // one transaction in flight: no acceptance right after another
    `MKV_ASSERT_NEXT(a_single_item, i_valid && o_ready, !o_ready, "second item accepted while busy")
    // a result is only loaded for a transaction that passed the checks
    `MKV_ASSERT_SAME(a_load_ok, w_cmd.load_out, w_stat.item_ok, "result loaded for a dropped item")
    // controller issues at most one command per cycle
    `MKV_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(w_cmd), "more than one datapath command")
    // memory init sweep never overlaps input acceptance
    `MKV_ASSERT_SAME(a_clear_blocks, w_cmd.clear, !o_ready, "input open during init sweep")

endmodule

// File: src/mkv_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module mkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/mkv_dp.sv
`timescale 1ns / 1ps

// Datapath: input capture, page divide, state memories, mask build, result register
module mkv_dp #(
    parameter int PROCESSES  = 20,
    parameter int PAGES      = 20,
    parameter int PAGE_BYTES = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mkv_pkg::t_in_item i_item,
    input  mkv_pkg::t_cmd     i_cmd,
    input  logic              i_out_ready,
    output mkv_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    output mkv_pkg::t_out_item o_out_item
);

    localparam int PW       = $clog2(PAGES);
    localparam int PRW      = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int DEPTH    = PROCESSES * (2 ** PW);
    localparam int SAW      = $clog2(DEPTH);
    localparam int DIV_SH   = mkv_pkg::PC_BITS + 16;
    localparam int RW       = DIV_SH + 1;
    localparam int PRODW    = mkv_pkg::PC_BITS + RW;
    localparam longint unsigned RECIP =
        ((64'd1 << DIV_SH) + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

    // Captured transaction
    logic [mkv_pkg::PROC_BITS-1:0] r_proc;
    logic                          r_active;
    logic [mkv_pkg::PC_BITS-1:0]   r_pc;
    logic [mkv_pkg::PC_BITS-1:0]   r_quot;

    // Per-item working registers
    logic [PW-1:0]        r_last;
    logic [PAGES-1:0]     r_row;
    logic [PAGES-1:0]     r_mask;
    logic                 r_take;
    logic [PW-1:0]        r_idx;
    logic [SAW-1:0]       r_clr;
    logic [PROCESSES-1:0] r_lp_valid;
    logic                 r_out_valid;
    mkv_pkg::t_out_item   r_out;

    logic [PRODW-1:0] w_prod;
    logic [PRW-1:0]   w_p;
    logic [PW-1:0]    w_cur;
    logic [PAGES-1:0] w_cur_oh;
    logic [PW-1:0]    w_clr_page;
    logic [PAGES-1:0] w_clr_row;

    logic [PW-1:0]    w_lp_rdata;
    logic             w_seen_rd_en;
    logic [SAW-1:0]   w_seen_rd_addr;
    logic             w_seen_wr_en;
    logic [SAW-1:0]   w_seen_wr_addr;
    logic [PAGES-1:0] w_seen_wr_data;
    logic [PAGES-1:0] w_seen_rdata;
    logic             w_snap_wr_en;
    logic [SAW-1:0]   w_snap_wr_addr;
    logic [PAGES-1:0] w_snap_wr_data;
    logic [PAGES-1:0] w_snap_rdata;

    // Page = pc / PAGE_BYTES by reciprocal multiply (exact for 12-bit pc)
    assign w_prod   = PRODW'(r_pc) * PRODW'(RECIP_V);
    assign w_p      = PRW'(r_proc);
    assign w_cur    = r_quot[PW-1:0];
    assign w_cur_oh = PAGES'(1) << w_cur;

    // Reset contents of a seen row: only the next page's bit, none for the last page
    assign w_clr_page = r_clr[PW-1:0];
    assign w_clr_row  = (32'(w_clr_page) < PAGES - 1) ?
                        (PAGES'(1) << (w_clr_page + PW'(1))) : '0;

    // Status
    assign o_stat.clear_done = (r_clr == SAW'(DEPTH - 1));
    assign o_stat.item_ok    = r_active && (32'(r_proc) < PROCESSES) &&
                               (32'(r_quot) < PAGES);
    assign o_stat.need_mark  = r_lp_valid[w_p] && (w_lp_rdata != w_cur);
    assign o_stat.scan_last  = (r_idx == PW'(PAGES - 1));
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    // Last page per process
    mkv_ram #(
        .WIDTH (PW),
        .DEPTH (PROCESSES)
    ) u_lp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.check),
        .i_wr_addr (w_p),
        .i_wr_data (w_cur),
        .i_rd_en   (i_cmd.div),
        .i_rd_addr (w_p),
        .o_rd_data (w_lp_rdata)
    );

    // Seen-transition rows, addressed {process, page}
    assign w_seen_rd_en   = i_cmd.check | i_cmd.row_rd;
    assign w_seen_rd_addr = i_cmd.check ? SAW'({w_p, w_lp_rdata}) : SAW'({w_p, w_cur});
    assign w_seen_wr_en   = i_cmd.clear | i_cmd.mark;
    assign w_seen_wr_addr = i_cmd.clear ? r_clr : SAW'({w_p, r_last});
    assign w_seen_wr_data = i_cmd.clear ? w_clr_row : (w_seen_rdata | w_cur_oh);

    mkv_ram #(
        .WIDTH (PAGES),
        .DEPTH (DEPTH)
    ) u_seen_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_seen_wr_en),
        .i_wr_addr (w_seen_wr_addr),
        .i_wr_data (w_seen_wr_data),
        .i_rd_en   (w_seen_rd_en),
        .i_rd_addr (w_seen_rd_addr),
        .o_rd_data (w_seen_rdata)
    );

    // Successor snapshot rows
    assign w_snap_wr_en   = i_cmd.clear | i_cmd.row_wr;
    assign w_snap_wr_addr = i_cmd.clear ? r_clr : SAW'({w_p, w_cur});
    assign w_snap_wr_data = i_cmd.clear ? '0 : w_seen_rdata;

    mkv_ram #(
        .WIDTH (PAGES),
        .DEPTH (DEPTH)
    ) u_snap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_snap_wr_en),
        .i_wr_addr (w_snap_wr_addr),
        .i_wr_data (w_snap_wr_data),
        .i_rd_en   (i_cmd.scan),
        .i_rd_addr (SAW'({w_p, r_idx})),
        .o_rd_data (w_snap_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_lp_valid  <= '0;
            r_take      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + SAW'(1);
            end
            if (i_cmd.check) begin
                r_lp_valid[w_p] <= 1'b1;
            end
            r_take <= i_cmd.scan && r_row[r_idx];
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_proc   <= i_item.process_index;
            r_active <= i_item.active;
            r_pc     <= i_item.pc;
        end
        if (i_cmd.div) begin
            r_quot <= w_prod[DIV_SH +: mkv_pkg::PC_BITS];
        end
        if (i_cmd.check) begin
            r_last <= w_lp_rdata;
        end
        // mask starts as current page plus its row, then ORs successor rows
        if (i_cmd.row_wr) begin
            r_row  <= w_seen_rdata;
            r_mask <= w_seen_rdata | w_cur_oh;
            r_idx  <= '0;
        end else begin
            if (i_cmd.scan) begin
                r_idx <= r_idx + PW'(1);
            end
            if (r_take) begin
                r_mask <= r_mask | w_snap_rdata;
            end
        end
        if (i_cmd.load_out) begin
            r_out.current_page  <= mkv_pkg::PAGE_FIELD_BITS'(w_cur);
            r_out.resident_mask <= mkv_pkg::MASK_BITS'(r_mask);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: src/mkv_ctrl.sv
`timescale 1ns / 1ps

// Controller: sequences one transaction at a time through the datapath
module mkv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mkv_pkg::t_stat i_stat,
    output logic           o_ready,
    output mkv_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_MARK  = 4'd4;
    localparam logic [3:0] S_ROWRD = 4'd5;
    localparam logic [3:0] S_ROWWR = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                // inactive, bad process or bad page: drop silently
                if (i_stat.item_ok) begin
                    o_cmd.check = 1'b1;
                    n_state     = i_stat.need_mark ? S_MARK : S_ROWRD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                n_state    = S_ROWRD;
            end
            S_ROWRD: begin
                o_cmd.row_rd = 1'b1;
                n_state      = S_ROWWR;
            end
            S_ROWWR: begin
                o_cmd.row_wr = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
